@@ hw/rtl/lz4_block_compressor_assert.svh @@
// Assertion macros used by the compressor's datapath module.
// Each macro expects signals named clk and rst_n in the scope of use.
`ifndef LZ4_BLOCK_COMPRESSOR_ASSERT_SVH
`define LZ4_BLOCK_COMPRESSOR_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define LZ4C_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define LZ4C_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/lz4c_pkg.sv @@
package lz4c_pkg;

  localparam int BLOCK_BYTES_DEF = 2048;
  localparam int HASH_BITS_DEF   = 11;
  localparam int OUT_BYTES_DEF   = 2072;

  localparam logic [11:0] CAP_RESET  = 12'd2072;
  localparam logic [31:0] HASH_MUL   = 32'd2654435761;
  localparam logic [31:0] MAX_OFFSET = 32'h0000_FFFF;
  localparam int          MIN_MATCH  = 4;
  localparam int          RUN_MASK   = 15;
  localparam int          EXT_BYTE   = 255;

  localparam logic       MODE_LOAD  = 1'b0;
  localparam logic       MODE_FETCH = 1'b1;
  localparam logic       KIND_SUM   = 1'b0;
  localparam logic       KIND_BYTE  = 1'b1;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OVER    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef enum logic [4:0] {
    OP_IDLE, OP_LOAD, OP_RESF, OP_FRD, OP_FRES, OP_START, OP_CLR,
    OP_WRD, OP_WSH, OP_MUL, OP_HRD, OP_HCHK, OP_RA, OP_RB, OP_EQ,
    OP_MSET, OP_FSET, OP_TOK, OP_LEXT, OP_LRD, OP_LPUT, OP_OFF0,
    OP_OFF1, OP_MXS, OP_MEXT, OP_ADV, OP_DONE
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic full;
    logic ip_ok;
    logic clr_done;
    logic k_last;
    logic cand;
    logic eq;
    logic m_more;
    logic m_ge4;
    logic lit_ge15;
    logic ml_ge15;
    logic left_ge255;
    logic lit_done;
    logic fin;
    logic put_over;
  } stat_t;

endpackage

@@ hw/rtl/lz4c_if.sv @@
interface lz4c_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] in_byte;
  logic       in_last;
  modport source(output valid, mode, in_byte, in_last, input ready);
  modport sink(input valid, mode, in_byte, in_last, output ready);
endinterface

interface lz4c_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [11:0] compressed_length;
  logic [1:0]  status;
  modport source(output valid, out_kind, out_byte, out_last, compressed_length, status,
                 input ready);
  modport sink(input valid, out_kind, out_byte, out_last, compressed_length, status,
               output ready);
endinterface

interface lz4c_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

@@ hw/rtl/lz4c_ctrl.sv @@
module lz4c_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_mode,
  input  logic             in_last,
  output logic             in_ready,
  input  lz4c_pkg::stat_t  stat,
  output lz4c_pkg::cmd_t   cmd
);

  typedef enum logic [26:0] {
    S_IDLE = 27'b1 << 0,  S_RESF = 27'b1 << 1,  S_FRD  = 27'b1 << 2,
    S_FRES = 27'b1 << 3,  S_STRT = 27'b1 << 4,  S_CLR  = 27'b1 << 5,
    S_MAIN = 27'b1 << 6,  S_WRD  = 27'b1 << 7,  S_WSH  = 27'b1 << 8,
    S_MUL  = 27'b1 << 9,  S_HRD  = 27'b1 << 10, S_HCHK = 27'b1 << 11,
    S_RA   = 27'b1 << 12, S_RB   = 27'b1 << 13, S_EQ   = 27'b1 << 14,
    S_MSET = 27'b1 << 15, S_FSET = 27'b1 << 16, S_TOK  = 27'b1 << 17,
    S_LEXT = 27'b1 << 18, S_LRD  = 27'b1 << 19, S_LPUT = 27'b1 << 20,
    S_OFF0 = 27'b1 << 21, S_OFF1 = 27'b1 << 22, S_MXS  = 27'b1 << 23,
    S_MEXT = 27'b1 << 24, S_ADV  = 27'b1 << 25, S_DONE = 27'b1 << 26
  } state_t;

  state_t state_r, state_nxt;
  logic   take;

  assign in_ready = (state_r == S_IDLE) && stat.out_free;
  assign take     = in_ready && in_valid;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = lz4c_pkg::OP_IDLE;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          if (in_mode == lz4c_pkg::MODE_FETCH) begin
            cmd.op    = lz4c_pkg::OP_FRD;
            state_nxt = S_FRD;
          end else begin
            cmd.op = lz4c_pkg::OP_LOAD;
            if (in_last) state_nxt = S_STRT;
            else if (stat.full) state_nxt = S_RESF;
          end
        end
      end
      S_RESF: begin
        cmd.op    = lz4c_pkg::OP_RESF;
        state_nxt = S_IDLE;
      end
      // The output memory address is held so that its read data stays valid.
      S_FRD: begin
        cmd.op    = lz4c_pkg::OP_FRD;
        state_nxt = S_FRES;
      end
      S_FRES: begin
        cmd.op    = lz4c_pkg::OP_FRES;
        state_nxt = S_IDLE;
      end
      S_STRT: begin
        cmd.op    = lz4c_pkg::OP_START;
        state_nxt = S_CLR;
      end
      S_CLR: begin
        cmd.op = lz4c_pkg::OP_CLR;
        if (stat.clr_done) state_nxt = S_MAIN;
      end
      S_MAIN: state_nxt = stat.ip_ok ? S_WRD : S_FSET;
      S_WRD: begin
        cmd.op = lz4c_pkg::OP_WRD;
        if (stat.k_last) state_nxt = S_WSH;
      end
      S_WSH: begin
        cmd.op    = lz4c_pkg::OP_WSH;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.op    = lz4c_pkg::OP_MUL;
        state_nxt = S_HRD;
      end
      S_HRD: begin
        cmd.op    = lz4c_pkg::OP_HRD;
        state_nxt = S_HCHK;
      end
      S_HCHK: begin
        cmd.op    = lz4c_pkg::OP_HCHK;
        state_nxt = stat.cand ? S_RA : S_MAIN;
      end
      S_RA: begin
        cmd.op    = lz4c_pkg::OP_RA;
        state_nxt = S_RB;
      end
      S_RB: begin
        cmd.op    = lz4c_pkg::OP_RB;
        state_nxt = S_EQ;
      end
      S_EQ: begin
        cmd.op = lz4c_pkg::OP_EQ;
        if (stat.eq) state_nxt = stat.m_more ? S_RA : S_MSET;
        else state_nxt = stat.m_ge4 ? S_MSET : S_MAIN;
      end
      S_MSET: begin
        cmd.op    = lz4c_pkg::OP_MSET;
        state_nxt = S_TOK;
      end
      S_FSET: begin
        cmd.op    = lz4c_pkg::OP_FSET;
        state_nxt = S_TOK;
      end
      S_TOK: begin
        cmd.op = lz4c_pkg::OP_TOK;
        if (stat.put_over) state_nxt = S_DONE;
        else state_nxt = stat.lit_ge15 ? S_LEXT : S_LRD;
      end
      S_LEXT: begin
        cmd.op = lz4c_pkg::OP_LEXT;
        if (stat.put_over) state_nxt = S_DONE;
        else if (!stat.left_ge255) state_nxt = S_LRD;
      end
      S_LRD: begin
        if (stat.lit_done) begin
          state_nxt = stat.fin ? S_DONE : S_OFF0;
        end else begin
          cmd.op    = lz4c_pkg::OP_LRD;
          state_nxt = S_LPUT;
        end
      end
      S_LPUT: begin
        cmd.op    = lz4c_pkg::OP_LPUT;
        state_nxt = stat.put_over ? S_DONE : S_LRD;
      end
      S_OFF0: begin
        cmd.op    = lz4c_pkg::OP_OFF0;
        state_nxt = stat.put_over ? S_DONE : S_OFF1;
      end
      S_OFF1: begin
        cmd.op    = lz4c_pkg::OP_OFF1;
        state_nxt = stat.put_over ? S_DONE : S_MXS;
      end
      S_MXS: begin
        cmd.op    = lz4c_pkg::OP_MXS;
        state_nxt = stat.ml_ge15 ? S_MEXT : S_ADV;
      end
      S_MEXT: begin
        cmd.op = lz4c_pkg::OP_MEXT;
        if (stat.put_over) state_nxt = S_DONE;
        else if (!stat.left_ge255) state_nxt = S_ADV;
      end
      S_ADV: begin
        cmd.op    = lz4c_pkg::OP_ADV;
        state_nxt = S_MAIN;
      end
      S_DONE: begin
        cmd.op    = lz4c_pkg::OP_DONE;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

@@ hw/rtl/lz4c_dp.sv @@
`include "lz4_block_compressor_assert.svh"

module lz4c_dp #(
  parameter int BLOCK_BYTES = lz4c_pkg::BLOCK_BYTES_DEF,
  parameter int HASH_BITS   = lz4c_pkg::HASH_BITS_DEF,
  parameter int OUT_BYTES   = lz4c_pkg::OUT_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  lz4c_pkg::cmd_t  cmd,
  input  logic [7:0]      in_byte,
  output lz4c_pkg::stat_t stat,
  lz4c_cfg_if.sink        cfg_s,
  lz4c_out_if.source      out_s
);

  localparam int PW  = $clog2(BLOCK_BYTES + 1);
  localparam int SAW = $clog2(BLOCK_BYTES);
  localparam int OW  = $clog2(OUT_BYTES + 1);
  localparam int OAW = $clog2(OUT_BYTES);
  localparam int HE  = 1 << HASH_BITS;

  logic [7:0]  src_mem [BLOCK_BYTES];
  logic [SAW:0] ht_mem [HE];
  logic [7:0]  out_mem [OUT_BYTES];

  logic [7:0]   src_q_r, out_q_r, a_r;
  logic [SAW:0] ht_q_r;

  logic [11:0]          cap_r;
  logic [PW-1:0]        count_r, n_r, ip_r, anchor_r, m_r, lit_r, left_r, i_r;
  logic [SAW-1:0]       ref_r;
  logic [1:0]           k_r;
  logic [31:0]          word_r, prod_r;
  logic                 fin_r, over_r;
  logic [HASH_BITS-1:0] clr_r;
  logic [OW-1:0]        wr_r, capw_r, len_r, fp_r;

  logic                 out_valid_r, out_kind_r, out_last_r;
  logic [7:0]           out_byte_r;
  logic [11:0]          out_len_r;
  logic [1:0]           out_status_r;

  logic [PW-1:0]        saddr, ml;
  logic                 src_we;
  logic [HASH_BITS-1:0] h, haddr;
  logic                 ht_we;
  logic [SAW:0]         ht_wd;
  logic [SAW-1:0]       ref_pos;
  logic [31:0]          cand_dist, off;
  logic                 is_put, put_over, fok, full;
  logic [7:0]           put_byte, ext_byte;
  logic [OAW-1:0]       oaddr;
  logic [OW-1:0]        capw_nxt;

  function automatic logic [3:0] sat_nib(input logic [PW-1:0] x);
    sat_nib = (x >= PW'(lz4c_pkg::RUN_MASK)) ? 4'd15 : x[3:0];
  endfunction

  assign full      = count_r >= PW'(BLOCK_BYTES);
  assign h         = prod_r[31 -: HASH_BITS];
  assign ref_pos   = ht_q_r[SAW-1:0];
  assign cand_dist = 32'(ip_r - PW'(ref_pos));
  assign off       = 32'(ip_r - PW'(ref_r));
  assign ml        = m_r - PW'(lz4c_pkg::MIN_MATCH);
  assign put_over  = wr_r >= capw_r;
  assign fok       = fp_r < len_r;
  assign ext_byte  = stat.left_ge255 ? 8'(lz4c_pkg::EXT_BYTE) : left_r[7:0];
  assign capw_nxt  = (32'(cap_r) < 32'(OUT_BYTES)) ? OW'(cap_r) : OW'(OUT_BYTES);

  assign stat.out_free   = !out_valid_r || out_s.ready;
  assign stat.full       = full;
  assign stat.ip_ok      = ({1'b0, ip_r} + (PW + 1)'(lz4c_pkg::MIN_MATCH)) <= {1'b0, n_r};
  assign stat.clr_done   = &clr_r;
  assign stat.k_last     = k_r == 2'd3;
  assign stat.cand       = ht_q_r[SAW] && (PW'(ref_pos) < ip_r) &&
                           (cand_dist <= lz4c_pkg::MAX_OFFSET);
  assign stat.eq         = src_q_r == a_r;
  assign stat.m_more     = ({1'b0, ip_r} + {1'b0, m_r} + (PW + 1)'(1)) < {1'b0, n_r};
  assign stat.m_ge4      = m_r >= PW'(lz4c_pkg::MIN_MATCH);
  assign stat.lit_ge15   = lit_r >= PW'(lz4c_pkg::RUN_MASK);
  assign stat.ml_ge15    = ml >= PW'(lz4c_pkg::RUN_MASK);
  assign stat.left_ge255 = left_r >= PW'(lz4c_pkg::EXT_BYTE);
  assign stat.lit_done   = i_r == lit_r;
  assign stat.fin        = fin_r;
  assign stat.put_over   = put_over;

  always_comb begin
    case (cmd.op)
      lz4c_pkg::OP_LOAD: saddr = count_r;
      lz4c_pkg::OP_WRD:  saddr = ip_r + PW'(k_r);
      lz4c_pkg::OP_RA:   saddr = PW'(ref_r) + m_r;
      lz4c_pkg::OP_RB:   saddr = ip_r + m_r;
      lz4c_pkg::OP_LRD:  saddr = anchor_r + i_r;
      default:           saddr = '0;
    endcase
  end
  assign src_we = (cmd.op == lz4c_pkg::OP_LOAD) && !full;

  assign haddr = (cmd.op == lz4c_pkg::OP_CLR) ? clr_r : h;
  assign ht_we = (cmd.op == lz4c_pkg::OP_CLR) || (cmd.op == lz4c_pkg::OP_HCHK);
  assign ht_wd = (cmd.op == lz4c_pkg::OP_CLR) ? '0 : {1'b1, ip_r[SAW-1:0]};

  always_comb begin
    is_put   = 1'b1;
    put_byte = 8'd0;
    case (cmd.op)
      lz4c_pkg::OP_TOK:  put_byte = {sat_nib(lit_r), fin_r ? 4'd0 : sat_nib(ml)};
      lz4c_pkg::OP_LEXT: put_byte = ext_byte;
      lz4c_pkg::OP_MEXT: put_byte = ext_byte;
      lz4c_pkg::OP_LPUT: put_byte = src_q_r;
      lz4c_pkg::OP_OFF0: put_byte = off[7:0];
      lz4c_pkg::OP_OFF1: put_byte = off[15:8];
      default:           is_put   = 1'b0;
    endcase
  end
  assign oaddr = (cmd.op == lz4c_pkg::OP_FRD) ? fp_r[OAW-1:0] : wr_r[OAW-1:0];

  always_ff @(posedge clk) begin
    if (src_we) src_mem[saddr[SAW-1:0]] <= in_byte;
    src_q_r <= src_mem[saddr[SAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ht_we) ht_mem[haddr] <= ht_wd;
    ht_q_r <= ht_mem[haddr];
  end

  always_ff @(posedge clk) begin
    if (is_put && !put_over) out_mem[oaddr] <= put_byte;
    out_q_r <= out_mem[oaddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= lz4c_pkg::CAP_RESET;
      count_r     <= '0;
      len_r       <= '0;
      fp_r        <= '0;
      wr_r        <= '0;
      capw_r      <= OW'(OUT_BYTES);
      over_r      <= 1'b0;
      out_valid_r <= 1'b0;
      n_r         <= '0;
      ip_r        <= '0;
      anchor_r    <= '0;
      m_r         <= '0;
      lit_r       <= '0;
      left_r      <= '0;
      i_r         <= '0;
      ref_r       <= '0;
      k_r         <= '0;
      clr_r       <= '0;
      fin_r       <= 1'b0;
    end else begin
      if (cfg_s.valid) cap_r <= cfg_s.data;
      // A new result is only loaded while the output register is empty.
      if (out_s.ready && out_valid_r) out_valid_r <= 1'b0;
      if (is_put) begin
        if (put_over) over_r <= 1'b1;
        else wr_r <= wr_r + OW'(1);
      end
      case (cmd.op)
        lz4c_pkg::OP_LOAD: if (!full) count_r <= count_r + PW'(1);
        lz4c_pkg::OP_RESF: out_valid_r <= 1'b1;
        lz4c_pkg::OP_FRES: begin
          out_valid_r <= 1'b1;
          if (fok) fp_r <= fp_r + OW'(1);
        end
        lz4c_pkg::OP_START: begin
          n_r      <= count_r;
          count_r  <= '0;
          ip_r     <= '0;
          anchor_r <= '0;
          wr_r     <= '0;
          over_r   <= 1'b0;
          clr_r    <= '0;
          capw_r   <= capw_nxt;
        end
        lz4c_pkg::OP_CLR:  clr_r <= clr_r + HASH_BITS'(1);
        lz4c_pkg::OP_WRD:  k_r <= k_r + 2'd1;
        lz4c_pkg::OP_HCHK: begin
          ref_r <= ref_pos;
          m_r   <= '0;
          if (!stat.cand) ip_r <= ip_r + PW'(1);
        end
        lz4c_pkg::OP_EQ: begin
          if (stat.eq) m_r <= m_r + PW'(1);
          else if (!stat.m_ge4) ip_r <= ip_r + PW'(1);
        end
        lz4c_pkg::OP_MSET: begin
          lit_r  <= ip_r - anchor_r;
          left_r <= ip_r - anchor_r - PW'(lz4c_pkg::RUN_MASK);
          i_r    <= '0;
          fin_r  <= 1'b0;
        end
        lz4c_pkg::OP_FSET: begin
          lit_r  <= n_r - anchor_r;
          left_r <= n_r - anchor_r - PW'(lz4c_pkg::RUN_MASK);
          i_r    <= '0;
          fin_r  <= 1'b1;
        end
        lz4c_pkg::OP_LEXT, lz4c_pkg::OP_MEXT: begin
          if (stat.left_ge255) left_r <= left_r - PW'(lz4c_pkg::EXT_BYTE);
        end
        lz4c_pkg::OP_LPUT: i_r <= i_r + PW'(1);
        lz4c_pkg::OP_MXS:  left_r <= ml - PW'(lz4c_pkg::RUN_MASK);
        lz4c_pkg::OP_ADV: begin
          ip_r     <= ip_r + m_r;
          anchor_r <= ip_r + m_r;
        end
        lz4c_pkg::OP_DONE: begin
          len_r       <= over_r ? '0 : wr_r;
          fp_r        <= '0;
          out_valid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Hash word and result payload; the word collects one source beat per cycle.
  always_ff @(posedge clk) begin
    if ((cmd.op == lz4c_pkg::OP_WRD) || (cmd.op == lz4c_pkg::OP_WSH))
      word_r <= {src_q_r, word_r[31:8]};
    if (cmd.op == lz4c_pkg::OP_MUL) prod_r <= word_r * lz4c_pkg::HASH_MUL;
    if (cmd.op == lz4c_pkg::OP_RB) a_r <= src_q_r;
    case (cmd.op)
      lz4c_pkg::OP_RESF: begin
        out_kind_r   <= lz4c_pkg::KIND_SUM;
        out_byte_r   <= 8'd0;
        out_last_r   <= 1'b0;
        out_len_r    <= 12'd0;
        out_status_r <= lz4c_pkg::ST_FULL;
      end
      lz4c_pkg::OP_FRES: begin
        out_kind_r   <= lz4c_pkg::KIND_BYTE;
        out_byte_r   <= fok ? out_q_r : 8'd0;
        out_last_r   <= fok && (({1'b0, fp_r} + (OW + 1)'(1)) == {1'b0, len_r});
        out_len_r    <= 12'(len_r);
        out_status_r <= fok ? lz4c_pkg::ST_OK : lz4c_pkg::ST_EMPTY;
      end
      lz4c_pkg::OP_DONE: begin
        out_kind_r   <= lz4c_pkg::KIND_SUM;
        out_byte_r   <= 8'd0;
        out_last_r   <= 1'b0;
        out_len_r    <= over_r ? 12'd0 : 12'(wr_r);
        out_status_r <= over_r ? lz4c_pkg::ST_OVER : lz4c_pkg::ST_OK;
      end
      default: ;
    endcase
  end

  assign cfg_s.ready             = 1'b1;
  assign out_s.valid             = out_valid_r;
  assign out_s.out_kind          = out_kind_r;
  assign out_s.out_byte          = out_byte_r;
  assign out_s.out_last          = out_last_r;
  assign out_s.compressed_length = out_len_r;
  assign out_s.status            = out_status_r;

  `LZ4C_ALWAYS(a_wr_cap, wr_r <= capw_r, "output write pointer passed the capacity")
  `LZ4C_ALWAYS(a_fetch_len, fp_r <= len_r, "fetch pointer passed the compressed length")
  `LZ4C_IMPLY(a_start_clear, cmd.op == lz4c_pkg::OP_START,
              count_r == '0 && wr_r == '0, "block start did not clear counters")

endmodule

@@ hw/rtl/lz4_block_compressor.sv @@
// Channel   Direction  Beat contents
// in_s      in         mode, in_byte, in_last
// out_s     out        out_kind, out_byte, out_last, compressed_length, status
// cfg_s     in         output capacity (12 bits), always ready
//
// A load beat is taken while idle; a fetch returns a byte read from the output memory.
// A block first clears the hash table, one entry at a time, then hashes each scanned
// position, compares candidate bytes and copies literals on the single source port.
// Reset clears counters and output valid and presets the capacity; memories keep data.
// A waiting result holds in the output register and no new beat is taken until it leaves.
module lz4_block_compressor #(
  parameter int BLOCK_BYTES = lz4c_pkg::BLOCK_BYTES_DEF,
  parameter int HASH_BITS   = lz4c_pkg::HASH_BITS_DEF,
  parameter int OUT_BYTES   = lz4c_pkg::OUT_BYTES_DEF
) (
  input logic         clk,
  input logic         rst_n,
  lz4c_in_if.sink     in_s,
  lz4c_out_if.source  out_s,
  lz4c_cfg_if.sink    cfg_s
);

  lz4c_pkg::cmd_t  cmd;
  lz4c_pkg::stat_t stat;

  lz4c_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_s.valid),
    .in_mode  (in_s.mode),
    .in_last  (in_s.in_last),
    .in_ready (in_s.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lz4c_dp #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .HASH_BITS   (HASH_BITS),
    .OUT_BYTES   (OUT_BYTES)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_byte (in_s.in_byte),
    .stat    (stat),
    .cfg_s   (cfg_s),
    .out_s   (out_s)
  );

endmodule
